// ===== rtl/box_blur_3x3_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Box blur 3x3 assertion macros
// Concurrent assertion helpers used by the box blur unit RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of aclk outside reset.
`define BB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every rising edge of aclk, reset included.
`define BB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BB_ASSERT(label, prop, msg)
`define BB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur 3x3 package
// Field widths, register indexes and shared types of the box blur unit.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 16;
    localparam int COLS_CFG_W = 10;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_COL_W  = 9;
    localparam int SUM_W      = 12;
    localparam int MIN_SIZE   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd1;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 10'd512;
    localparam logic [ROW_W-1:0]      ROWS_RESET = 16'd512;

    // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255.
    localparam int               RECIP_W     = 13;
    localparam int               RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    typedef struct packed {
        logic load;   // read the line store entry of the accepted pixel
        logic shift;  // write the entry back and shift the window
    } bb3_win_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0]     blurred;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } bb3_result_t;

endpackage

// ===== rtl/bb3_window.sv =====
// ----------------------------------------------------------------------------
// Box blur line store and window
// Paired line store memory with read-modify-write and the 3x3 window.
// ----------------------------------------------------------------------------
module bb3_window import bb3_pkg::*; #(
    parameter int MAX_WIDTH = 512,
    parameter int AW        = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bb3_win_ctl_t       ctl,
    input  logic [AW-1:0]      rd_addr,
    input  logic [AW-1:0]      wr_addr,
    input  logic [PIX_W-1:0]   pixel,
    output logic [SUM_W-1:0]   win_sum
);

    // Each word holds the row two above (upper byte) and the row above.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [PIX_W-1:0]   win_reg [9];
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;

    assign top = rd_data_reg[2*PIX_W-1:PIX_W];
    assign mid = rd_data_reg[PIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            line_mem[wr_addr] <= {mid, pixel};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (ctl.shift) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k*3]     <= win_reg[k*3 + 1];
                win_reg[k*3 + 1] <= win_reg[k*3 + 2];
            end
            win_reg[2] <= top;
            win_reg[5] <= mid;
            win_reg[8] <= pixel;
        end
    end

    logic [SUM_W-1:0] col_sum [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            col_sum[j] = SUM_W'(win_reg[j]) + SUM_W'(win_reg[j + 3])
                       + SUM_W'(win_reg[j + 6]);
        end
        win_sum = col_sum[0] + col_sum[1] + col_sum[2];
    end

endmodule

// ===== rtl/box_blur_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// Box blur 3x3 unit
// Streaming 3x3 box blur over 8-bit grayscale frames in raster order.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_pixel_in
// m_        out        m_valid / m_ready   m_blurred, m_out_row, m_out_col, m_frame_last
// cfg_      in         cfg_wr_en           cfg_addr, cfg_wr_data
//
// One pixel per clock is taken while s_ready is high; the line store is read
// in the accept cycle and written back from stage 1, so the single memory
// port pair sets it. A result passes stages 1, 2 and 3 and the output register.
// Reset clears the counters, the window and the valid flags; the line store
// holds nothing useful until a frame's first two rows have passed through.
// s_ready falls only while the skid register holds a result.
`include "box_blur_3x3_unit_defines.svh"

module box_blur_3x3_unit import bb3_pkg::*; #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_blurred,
    output logic [ROW_W-1:0]      m_out_row,
    output logic [OUT_COL_W-1:0]  m_out_col,
    output logic                  m_frame_last
);

    localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    // Configuration
    logic [COLS_CFG_W-1:0] image_cols_reg;
    logic [ROW_W-1:0]      image_rows_reg;
    logic [AW:0]           cols_eff;
    logic [ROW_W-1:0]      rows_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_cols_reg <= COLS_RESET;
            image_rows_reg <= ROWS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_COLS: image_cols_reg <= cfg_wr_data[COLS_CFG_W-1:0];
                REG_IMAGE_ROWS: image_rows_reg <= cfg_wr_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (image_cols_reg < COLS_CFG_W'(MIN_SIZE)) begin
            cols_eff = (AW+1)'(MIN_SIZE);
        end else if (32'(image_cols_reg) > MAX_WIDTH) begin
            cols_eff = (AW+1)'(MAX_WIDTH);
        end else begin
            cols_eff = (AW+1)'(image_cols_reg);
        end
        if (image_rows_reg < ROW_W'(MIN_SIZE)) begin
            rows_eff = ROW_W'(MIN_SIZE);
        end else begin
            rows_eff = image_rows_reg;
        end
    end

    // Pipeline control: every stage moves while the skid register is empty.
    logic         skid_valid_reg;
    logic         adv;
    logic         accept;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // Stage 0: position counters
    logic [AW-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [AW:0]      col_inc;
    logic [ROW_W:0]   row_inc;
    logic             res0;
    logic             last0;
    logic [31:0]      col_m1;

    always_comb begin
        col_inc = {1'b0, col_cnt_reg} + (AW+1)'(1);
        row_inc = {1'b0, row_cnt_reg} + (ROW_W+1)'(1);
        col_m1  = 32'(col_cnt_reg) - 32'd1;
        res0    = (row_cnt_reg >= ROW_W'(2)) && ({1'b0, col_cnt_reg} >= (AW+1)'(2))
                && (row_cnt_reg < rows_eff) && ({1'b0, col_cnt_reg} < cols_eff);
        last0   = (row_cnt_reg == rows_eff - ROW_W'(1))
                && ({1'b0, col_cnt_reg} == cols_eff - (AW+1)'(1));
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (col_inc >= cols_eff) begin
            col_cnt_next = '0;
            if (row_inc >= {1'b0, rows_eff}) begin
                row_cnt_next = '0;
            end else begin
                row_cnt_next = row_inc[ROW_W-1:0];
            end
        end else begin
            col_cnt_next = col_inc[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Stage 1: line store read pending
    logic                 v1_reg, res1_reg, last1_reg;
    logic [PIX_W-1:0]     px1_reg;
    logic [AW-1:0]        addr1_reg;
    logic [ROW_W-1:0]     row1_reg;
    logic [OUT_COL_W-1:0] col1_reg;

    // Stage 2: window complete
    logic                 res2_reg, last2_reg;
    logic [ROW_W-1:0]     row2_reg;
    logic [OUT_COL_W-1:0] col2_reg;

    // Stage 3: window sum registered
    logic                 res3_reg, last3_reg;
    logic [ROW_W-1:0]     row3_reg;
    logic [OUT_COL_W-1:0] col3_reg;
    logic [SUM_W-1:0]     sum3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            res1_reg <= 1'b0;
            res2_reg <= 1'b0;
            res3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg   <= s_valid;
            res1_reg <= s_valid && res0;
            res2_reg <= v1_reg && res1_reg;
            res3_reg <= res2_reg;
        end
    end

    bb3_win_ctl_t     win_ctl;
    logic [SUM_W-1:0] win_sum;

    assign win_ctl.load  = accept;
    assign win_ctl.shift = adv && v1_reg;

    bb3_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (win_ctl),
        .rd_addr (col_cnt_reg),
        .wr_addr (addr1_reg),
        .pixel   (px1_reg),
        .win_sum (win_sum)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            px1_reg   <= s_pixel_in;
            addr1_reg <= col_cnt_reg;
            row1_reg  <= row_cnt_reg - ROW_W'(1);
            col1_reg  <= col_m1[OUT_COL_W-1:0];
            last1_reg <= last0;
        end
        if (adv) begin
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            last2_reg <= last1_reg;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            last3_reg <= last2_reg;
            sum3_reg  <= win_sum;
        end
    end

    // Division by nine and output register with skid
    logic [SUM_W+RECIP_W-1:0] prod;
    logic                     push;
    bb3_result_t              push_data;
    bb3_result_t              out_reg, out_next, skid_reg, skid_next;
    logic                     m_valid_reg, m_valid_next, skid_valid_next;

    assign prod = (SUM_W+RECIP_W)'(sum3_reg) * (SUM_W+RECIP_W)'(RECIP_NINE);
    assign push = adv && res3_reg;

    always_comb begin
        push_data.blurred = prod[RECIP_SHIFT +: PIX_W];
        push_data.row     = row3_reg;
        push_data.col     = col3_reg;
        push_data.last    = last3_reg;
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = push;
                out_next     = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_blurred    = out_reg.blurred;
    assign m_out_row    = out_reg.row;
    assign m_out_col    = out_reg.col;
    assign m_frame_last = out_reg.last;

    // A pending result in the skid register always sits behind a shown one.
    `BB_ASSERT(a_skid_behind_out, skid_valid_reg |-> m_valid_reg, "skid full with output empty")
    // The read-modify-write never reads the entry that is being written back.
    `BB_ASSERT(a_no_rmw_overlap, (win_ctl.load && win_ctl.shift) |-> (col_cnt_reg != addr1_reg), "line store read and write collide")
    `BB_ASSERT(a_col_in_range, col_cnt_reg <= AW'(MAX_WIDTH - 1), "column counter beyond line store")
    `BB_ASSERT_ALWAYS(a_reset_flush, !aresetn |=> (!m_valid_reg && !skid_valid_reg && !v1_reg), "valid flags survive reset")

endmodule
